// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define JTC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define JTC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/jtc_pkg.sv
`default_nettype none
package jtc_pkg;

  localparam int MAX_SPECIES = 256;
  localparam int CONC_AW     = $clog2(MAX_SPECIES);
  localparam int DW          = 64;

  localparam logic [8:0]    SPECIES_RESET = 9'd8;
  localparam logic [DW-1:0] DEFAULT_NAN   = 64'hFFF8_0000_0000_0000;
  localparam logic [DW-1:0] QUIET_BIT     = 64'h0008_0000_0000_0000;

  typedef enum logic [1:0] {
    FOP_MUL,
    FOP_ADD,
    FOP_SUB
  } fop_e;

  typedef struct packed {
    logic          start;
    fop_e          op;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic          done;
    logic          busy;
    logic [DW-1:0] res;
  } fpu_rsp_t;

endpackage
`default_nettype wire

// File: src/jacobian_temperature_column.sv
// concentration load beat: stored without leaving idle, next beat taken in the following cycle
// matrix element beat: read (index in store only), two multiplies, one add in the shared fp unit
// temperature column beat: three multiplies, one subtract, one add; result then in output reg
// cancellation in an add and subnormal operands lengthen the normalising shift
// async active-low reset: species count 8, alpha +0, row sum +0, row counter 0, store not cleared
`default_nettype none
`include "assert_macros.svh"
module jacobian_temperature_column import jtc_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_index_i,
  input  wire logic [DW-1:0] cfg_data_i,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic          func_i,
  input  wire logic [8:0]    col_index_i,
  input  wire logic [DW-1:0] value_bits_i,
  input  wire logic [DW-1:0] weight_bits_i,
  input  wire logic [DW-1:0] rate_bits_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [7:0]         row_index_o,
  output logic [DW-1:0]      dy_bits_o,
  output logic [DW-1:0]      jac_bits_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_PROD,
    S_TERM,
    S_ACC,
    S_DY,
    S_DIFF,
    S_LEFT,
    S_RIGHT,
    S_JAC,
    S_EMIT
  } st_e;

  typedef enum logic {
    REG_SPECIES = 1'b0,
    REG_ALPHA   = 1'b1
  } reg_e;

  st_e           state_q, state_d;
  fpu_req_t      req_q, req_d;
  fpu_rsp_t      rsp;
  logic [DW-1:0] val_q, val_d, w_q, w_d, tmp_q, tmp_d, dy_q, dy_d;
  logic [DW-1:0] sum_q, sum_d, alpha_q, alpha_d;
  logic [8:0]    spc_q, spc_d;
  logic [7:0]    row_q, row_d;
  logic          ov_q, ov_d;
  logic [7:0]    orow_q, orow_d;
  logic [DW-1:0] ody_q, ody_d, ojac_q, ojac_d;

  logic               acc_in;
  logic               in_store;
  logic               ram_we, ram_re;
  logic [CONC_AW-1:0] ram_addr;
  logic [DW-1:0]      ram_rdata;

  assign acc_in   = in_valid_i && (state_q == S_IDLE);
  assign in_store = (32'(col_index_i) < 32'(MAX_SPECIES));
  assign ram_addr = CONC_AW'(col_index_i);
  assign ram_we   = acc_in && !func_i && in_store;
  assign ram_re   = acc_in && func_i && (col_index_i < spc_q) && in_store;

  jtc_ram #(
    .WIDTH(DW),
    .DEPTH(MAX_SPECIES)
  ) u_conc (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_addr),
    .wdata_i(value_bits_i),
    .re_i   (ram_re),
    .raddr_i(ram_addr),
    .rdata_o(ram_rdata)
  );

  jtc_fpu u_fpu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_q),
    .rsp_o (rsp)
  );

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    req_d.start = 1'b0;
    val_d     = val_q;
    w_d       = w_q;
    tmp_d     = tmp_q;
    dy_d      = dy_q;
    sum_d     = sum_q;
    alpha_d   = alpha_q;
    spc_d     = spc_q;
    row_d     = row_q;
    ov_d      = ov_q && out_stall_i;
    orow_d    = orow_q;
    ody_d     = ody_q;
    ojac_d    = ojac_q;

    if (cfg_we_i) begin
      case (reg_e'(cfg_index_i))
        REG_SPECIES: spc_d   = cfg_data_i[8:0];
        REG_ALPHA:   alpha_d = cfg_data_i;
        default:     ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (acc_in && func_i) begin
          val_d = value_bits_i;
          w_d   = weight_bits_i;
          if (col_index_i < spc_q) begin
            if (in_store) begin
              state_d = S_RD;
            end else begin
              req_d   = '{start: 1'b1, op: FOP_MUL, a: value_bits_i, b: '0};
              state_d = S_PROD;
            end
          end else if (col_index_i == spc_q) begin
            req_d   = '{start: 1'b1, op: FOP_MUL, a: weight_bits_i, b: rate_bits_i};
            state_d = S_DY;
          end
        end
      end
      S_RD: begin
        req_d   = '{start: 1'b1, op: FOP_MUL, a: val_q, b: ram_rdata};
        state_d = S_PROD;
      end
      S_PROD: begin
        if (rsp.done) begin
          req_d   = '{start: 1'b1, op: FOP_MUL, a: rsp.res, b: alpha_q};
          state_d = S_TERM;
        end
      end
      S_TERM: begin
        if (rsp.done) begin
          req_d   = '{start: 1'b1, op: FOP_ADD, a: sum_q, b: rsp.res};
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        if (rsp.done) begin
          sum_d   = rsp.res;
          state_d = S_IDLE;
        end
      end
      S_DY: begin
        if (rsp.done) begin
          dy_d    = rsp.res;
          req_d   = '{start: 1'b1, op: FOP_SUB, a: val_q, b: sum_q};
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        if (rsp.done) begin
          req_d   = '{start: 1'b1, op: FOP_MUL, a: w_q, b: rsp.res};
          state_d = S_LEFT;
        end
      end
      S_LEFT: begin
        if (rsp.done) begin
          tmp_d   = rsp.res;
          req_d   = '{start: 1'b1, op: FOP_MUL, a: alpha_q, b: dy_q};
          state_d = S_RIGHT;
        end
      end
      S_RIGHT: begin
        if (rsp.done) begin
          req_d   = '{start: 1'b1, op: FOP_ADD, a: tmp_q, b: rsp.res};
          state_d = S_JAC;
        end
      end
      S_JAC: begin
        if (rsp.done) begin
          tmp_d   = rsp.res;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d    = 1'b1;
          orow_d  = row_q;
          ody_d   = dy_q;
          ojac_d  = tmp_q;
          sum_d   = '0;
          row_d   = row_q + 8'd1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q   <= '0;
      val_q   <= '0;
      w_q     <= '0;
      tmp_q   <= '0;
      dy_q    <= '0;
      sum_q   <= '0;
      alpha_q <= '0;
      spc_q   <= SPECIES_RESET;
      row_q   <= '0;
      ov_q    <= 1'b0;
      orow_q  <= '0;
      ody_q   <= '0;
      ojac_q  <= '0;
    end else begin
      state_q <= state_d;
      req_q   <= req_d;
      val_q   <= val_d;
      w_q     <= w_d;
      tmp_q   <= tmp_d;
      dy_q    <= dy_d;
      sum_q   <= sum_d;
      alpha_q <= alpha_d;
      spc_q   <= spc_d;
      row_q   <= row_d;
      ov_q    <= ov_d;
      orow_q  <= orow_d;
      ody_q   <= ody_d;
      ojac_q  <= ojac_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign row_index_o = orow_q;
  assign dy_bits_o   = ody_q;
  assign jac_bits_o  = ojac_q;

  `JTC_ASSERT_IMP(a_done_waited, clk_i, rst_ni, rsp.done, (state_q != S_IDLE) && (state_q != S_RD) && (state_q != S_EMIT), "fp result with no operation pending")
  `JTC_ASSERT_IMP(a_start_free, clk_i, rst_ni, req_q.start, !rsp.busy, "fp start while unit busy")
  `JTC_ASSERT_NXT(a_row_adv, clk_i, rst_ni, (state_q != S_EMIT), $stable(row_q), "row counter moved outside emit")

endmodule
`default_nettype wire

// File: src/jtc_ram.sv
`default_nettype none
module jtc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: src/jtc_fpu.sv
`default_nettype none
module jtc_fpu import jtc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire fpu_req_t req_i,
  output fpu_rsp_t      rsp_o
);

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_MPACK,
    F_ALIGN,
    F_ADD,
    F_NORM,
    F_ROUND
  } fst_e;

  fst_e               state_q, state_d;
  logic               done_q, done_d;
  logic [DW-1:0]      res_q, res_d;
  logic               sa_q, sa_d, sb_q, sb_d, s_q, s_d, sub_q, sub_d;
  logic signed [12:0] ea_q, ea_d, eb_q, eb_d, e_q, e_d;
  logic [52:0]        siga_q, siga_d, sigb_q, sigb_d;
  logic [1:0]         cnt_q, cnt_d;
  logic [105:0]       acc_q, acc_d;
  logic [63:0]        man_q, man_d, big_q, big_d, sml_q, sml_d;

  // operand decode
  logic [DW-1:0] b_eff;
  logic [10:0]   a_exp, b_exp;
  logic          a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, is_mul;

  // multiply step
  logic [26:0]  pa, pb;
  logic [53:0]  pp;
  logic [105:0] pp_sh;

  // align
  logic               a_ge;
  logic signed [12:0] e_big, e_sml, dexp;
  logic [52:0]        sig_big, sig_sml;
  logic [63:0]        sm64, shd;
  logic               sm_st;

  // normalise and round
  logic signed [12:0] rsh, er;
  logic [63:0]        rman;
  logic [52:0]        sigr;
  logic [53:0]        sum54;
  logic               rinc;

  always_comb begin
    a_exp  = req_i.a[62:52];
    b_exp  = req_i.b[62:52];
    a_nan  = (&a_exp) && (|req_i.a[51:0]);
    b_nan  = (&b_exp) && (|req_i.b[51:0]);
    a_inf  = (&a_exp) && !(|req_i.a[51:0]);
    b_inf  = (&b_exp) && !(|req_i.b[51:0]);
    a_zero = (req_i.a[62:0] == 63'd0);
    b_zero = (req_i.b[62:0] == 63'd0);
    is_mul = (req_i.op == FOP_MUL);
    b_eff  = (req_i.op == FOP_SUB) ? {~req_i.b[63], req_i.b[62:0]} : req_i.b;
  end

  always_comb begin
    pa = cnt_q[1] ? siga_q[52:26] : {1'b0, siga_q[25:0]};
    pb = cnt_q[0] ? sigb_q[52:26] : {1'b0, sigb_q[25:0]};
    pp = pa * pb;
    case (cnt_q)
      2'd0:    pp_sh = 106'(pp);
      2'd3:    pp_sh = 106'(pp) << 52;
      default: pp_sh = 106'(pp) << 26;
    endcase
  end

  always_comb begin
    a_ge    = (ea_q > eb_q) || ((ea_q == eb_q) && (siga_q >= sigb_q));
    e_big   = a_ge ? ea_q : eb_q;
    e_sml   = a_ge ? eb_q : ea_q;
    sig_big = a_ge ? siga_q : sigb_q;
    sig_sml = a_ge ? sigb_q : siga_q;
    dexp    = e_big - e_sml;
    sm64    = {1'b0, sig_sml, 10'd0};
    if (dexp > 13'sd63) begin
      shd   = 64'd0;
      sm_st = |sm64;
    end else begin
      shd   = sm64 >> dexp[5:0];
      sm_st = |(sm64 & ~({64{1'b1}} << dexp[5:0]));
    end
  end

  always_comb begin
    rsh = 13'sd1 - e_q;
    if (rsh > 13'sd63) begin
      rman = 64'd1;
    end else begin
      rman = (man_q >> rsh[5:0]) | 64'(|(man_q & ~({64{1'b1}} << rsh[5:0])));
    end
    rinc  = man_q[10] && ((|man_q[9:0]) || man_q[11]);
    sum54 = {1'b0, man_q[63:11]} + 54'(rinc);
    if (sum54[53]) begin
      sigr = sum54[53:1];
      er   = e_q + 13'sd1;
    end else begin
      sigr = sum54[52:0];
      er   = e_q;
    end
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    res_d   = res_q;
    sa_d    = sa_q;
    sb_d    = sb_q;
    s_d     = s_q;
    sub_d   = sub_q;
    ea_d    = ea_q;
    eb_d    = eb_q;
    e_d     = e_q;
    siga_d  = siga_q;
    sigb_d  = sigb_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    man_d   = man_q;
    big_d   = big_q;
    sml_d   = sml_q;
    case (state_q)
      F_IDLE: begin
        if (req_i.start) begin
          sa_d   = req_i.a[63];
          sb_d   = b_eff[63];
          ea_d   = (a_exp == 11'd0) ? 13'sd1 : $signed({2'b00, a_exp});
          eb_d   = (b_exp == 11'd0) ? 13'sd1 : $signed({2'b00, b_exp});
          siga_d = {a_exp != 11'd0, req_i.a[51:0]};
          sigb_d = {b_exp != 11'd0, req_i.b[51:0]};
          cnt_d  = 2'd0;
          acc_d  = 106'd0;
          if (a_nan) begin
            res_d  = req_i.a | QUIET_BIT;
            done_d = 1'b1;
          end else if (b_nan) begin
            res_d  = req_i.b | QUIET_BIT;
            done_d = 1'b1;
          end else if (is_mul) begin
            if (a_inf || b_inf) begin
              res_d  = (a_zero || b_zero) ? DEFAULT_NAN :
                       {req_i.a[63] ^ req_i.b[63], 11'h7FF, 52'd0};
              done_d = 1'b1;
            end else if (a_zero || b_zero) begin
              res_d  = {req_i.a[63] ^ req_i.b[63], 63'd0};
              done_d = 1'b1;
            end else begin
              state_d = F_MUL;
            end
          end else begin
            if (a_inf && b_inf) begin
              res_d  = (req_i.a[63] != b_eff[63]) ? DEFAULT_NAN : req_i.a;
              done_d = 1'b1;
            end else if (a_inf) begin
              res_d  = req_i.a;
              done_d = 1'b1;
            end else if (b_inf) begin
              res_d  = b_eff;
              done_d = 1'b1;
            end else if (a_zero && b_zero) begin
              res_d  = {req_i.a[63] & b_eff[63], 63'd0};
              done_d = 1'b1;
            end else if (a_zero) begin
              res_d  = b_eff;
              done_d = 1'b1;
            end else if (b_zero) begin
              res_d  = req_i.a;
              done_d = 1'b1;
            end else begin
              state_d = F_ALIGN;
            end
          end
        end
      end
      F_MUL: begin
        acc_d = acc_q + pp_sh;
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = F_MPACK;
        end
      end
      F_MPACK: begin
        man_d   = {acc_q[105:43], acc_q[42] | (|acc_q[41:0])};
        e_d     = ea_q + eb_q - 13'sd1022;
        s_d     = sa_q ^ sb_q;
        state_d = F_NORM;
      end
      F_ALIGN: begin
        big_d   = {1'b0, sig_big, 10'd0};
        sml_d   = {shd[63:1], shd[0] | sm_st};
        e_d     = e_big + 13'sd1;
        s_d     = a_ge ? sa_q : sb_q;
        sub_d   = (sa_q != sb_q);
        state_d = F_ADD;
      end
      F_ADD: begin
        man_d   = sub_q ? (big_q - sml_q) : (big_q + sml_q);
        state_d = F_NORM;
      end
      F_NORM: begin
        if (man_q == 64'd0) begin
          res_d   = 64'd0;
          done_d  = 1'b1;
          state_d = F_IDLE;
        end else if (e_q < 13'sd1) begin
          man_d = rman;
          e_d   = 13'sd1;
        end else if (!man_q[63] && (e_q > 13'sd1)) begin
          if ((man_q[63:48] == 16'd0) && (e_q > 13'sd16)) begin
            man_d = man_q << 16;
            e_d   = e_q - 13'sd16;
          end else begin
            man_d = man_q << 1;
            e_d   = e_q - 13'sd1;
          end
        end else begin
          state_d = F_ROUND;
        end
      end
      F_ROUND: begin
        if (er >= 13'sd2047) begin
          res_d = {s_q, 11'h7FF, 52'd0};
        end else begin
          res_d = {s_q, sigr[52] ? er[10:0] : 11'd0, sigr[51:0]};
        end
        done_d  = 1'b1;
        state_d = F_IDLE;
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      done_q  <= 1'b0;
      res_q   <= '0;
      sa_q    <= 1'b0;
      sb_q    <= 1'b0;
      s_q     <= 1'b0;
      sub_q   <= 1'b0;
      ea_q    <= '0;
      eb_q    <= '0;
      e_q     <= '0;
      siga_q  <= '0;
      sigb_q  <= '0;
      cnt_q   <= '0;
      acc_q   <= '0;
      man_q   <= '0;
      big_q   <= '0;
      sml_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      res_q   <= res_d;
      sa_q    <= sa_d;
      sb_q    <= sb_d;
      s_q     <= s_d;
      sub_q   <= sub_d;
      ea_q    <= ea_d;
      eb_q    <= eb_d;
      e_q     <= e_d;
      siga_q  <= siga_d;
      sigb_q  <= sigb_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      man_q   <= man_d;
      big_q   <= big_d;
      sml_q   <= sml_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = (state_q != F_IDLE);
  assign rsp_o.res  = res_q;

endmodule
`default_nettype wire
